FILE: rtl/vnm_pkg.sv
// ----------------------------------------------------------------------------
// vnm_pkg
// Shared constants for the vector normalize / magnitude pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vnm_pkg;

  // number of vector components handled side by side
  localparam int LANES = 3;

  // result field widths
  localparam int DIR_W   = 16;
  localparam int SPEED_W = 32;

  // result bus: dir_x, dir_y, dir_z, speed (80 bits, whole bytes)
  localparam int OUT_TDATA_W = LANES * DIR_W + SPEED_W;

endpackage

`default_nettype wire

FILE: rtl/vnm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vnm_sqrt_cell
// One digit of a restoring integer square root: brings down two radicand
// bits, tries the next root bit and registers the partial result.
// ----------------------------------------------------------------------------
`default_nettype none

module vnm_sqrt_cell
  import vnm_pkg::*;
#(
  parameter int RW     = 33,
  parameter int SIDE_W = 99
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*RW-1:0]     in_rad,
  input  logic [RW+1:0]       in_rem,
  input  logic [RW-1:0]       in_root,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [2*RW-1:0]     out_rad,
  output logic [RW+1:0]       out_rem,
  output logic [RW-1:0]       out_root,
  output logic [SIDE_W-1:0]   out_side
);

  logic [RW+3:0] cur;
  logic [RW+3:0] trial;
  logic          fits;
  logic [RW+1:0] rem_next;
  logic [RW-1:0] root_next;

  // trial subtract of (4*root + 1)
  always_comb begin
    cur   = {in_rem, in_rad[2*RW-1 -: 2]};
    trial = {2'b00, in_root, 2'b01};
    fits  = (cur >= trial);
    if (fits) begin
      rem_next  = (RW+2)'(cur - trial);
      root_next = {in_root[RW-2:0], 1'b1};
    end else begin
      rem_next  = cur[RW+1:0];
      root_next = {in_root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[2*RW-3:0], 2'b00};
      out_rem  <= rem_next;
      out_root <= root_next;
      out_side <= in_side;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vnm_div_cell.sv
// ----------------------------------------------------------------------------
// vnm_div_cell
// One quotient bit of a restoring fractional divide, for all three
// components at once, against the shared divisor (the root).
// ----------------------------------------------------------------------------
`default_nettype none

module vnm_div_cell
  import vnm_pkg::*;
#(
  parameter int RW    = 33,
  parameter int QW    = 15,
  parameter bit FIRST = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [RW-1:0]             in_d,
  input  logic [LANES-1:0][RW:0]    in_r,
  input  logic [LANES-1:0][QW-1:0]  in_q,
  input  logic [LANES-1:0]          in_neg,
  output logic                      out_valid,
  output logic [RW-1:0]             out_d,
  output logic [LANES-1:0][RW:0]    out_r,
  output logic [LANES-1:0][QW-1:0]  out_q,
  output logic [LANES-1:0]          out_neg
);

  logic [LANES-1:0][RW:0]   r_next;
  logic [LANES-1:0][QW-1:0] q_next;

  // first cell compares the magnitude itself, later cells the doubled rest
  always_comb begin
    logic [RW:0] rs;
    for (int l = 0; l < LANES; l++) begin
      rs = FIRST ? in_r[l] : {in_r[l][RW-1:0], 1'b0};
      if (rs >= {1'b0, in_d}) begin
        r_next[l] = rs - {1'b0, in_d};
        q_next[l] = {in_q[l][QW-2:0], 1'b1};
      end else begin
        r_next[l] = rs;
        q_next[l] = {in_q[l][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d   <= in_d;
      out_r   <= r_next;
      out_q   <= q_next;
      out_neg <= in_neg;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vector3_normalize_magnitude_unit.sv
// ----------------------------------------------------------------------------
// vector3_normalize_magnitude_unit
// Length and unit direction of a signed Q16.16 3-vector.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one vector per transfer: vel_x, vel_y, vel_z, IN_WIDTH bits
//   each, two's complement. m_* returns one result per vector: dir_x, dir_y,
//   dir_z (signed, DIR_FRAC fraction bits, zero for a zero vector) and speed
//   (unsigned Q16.16 truncated length, saturated to 32 bits).
//   The datapath is a row of registered cells: three stages form the sum of
//   squares, IN_WIDTH+1 cells produce one root bit each, DIR_FRAC+1 cells
//   produce one quotient bit each, and an output register formats the result.
//   One vector is taken every cycle while the row is not held:
//   All stages advance together while the output register is empty or being
//   taken; when the receiver holds m_tready low with a result pending, the
//   whole row holds and s_tready drops.
//   Reset clears every valid bit; the row is empty and ready right after.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalize_magnitude_unit
  import vnm_pkg::*;
#(
  parameter int IN_WIDTH = 32,
  parameter int DIR_FRAC = 14
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // vel_x, vel_y, vel_z (IN_WIDTH each), zero fill
  input  logic [((LANES*IN_WIDTH+7)/8)*8-1:0]        s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // dir_x, dir_y, dir_z (16 each), speed (32)
  output logic [OUT_TDATA_W-1:0]                    m_tdata
);

  localparam int W      = IN_WIDTH;
  localparam int RW     = W + 1;
  localparam int SW     = 2 * RW;
  localparam int QW     = DIR_FRAC + 1;
  localparam int K      = (W + 1) / 2;
  localparam int HW     = W - K;
  localparam int SIDE_W = LANES * W + LANES;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // --------------------------------------------------------------------------
  // stage 0: magnitudes and half-width partial products
  logic [LANES-1:0][W-1:0]    mag_in;
  logic [LANES-1:0]           neg_in;
  logic                       v0;
  logic [LANES-1:0][W-1:0]    mag0;
  logic [LANES-1:0]           neg0;
  logic [LANES-1:0][2*HW-1:0] hh0;
  logic [LANES-1:0][W-1:0]    hl0;
  logic [LANES-1:0][2*K-1:0]  ll0;

  always_comb begin
    logic [W-1:0] raw;
    for (int l = 0; l < LANES; l++) begin
      raw       = s_tdata[l*W +: W];
      neg_in[l] = raw[W-1];
      mag_in[l] = raw[W-1] ? (~raw + 1'b1) : raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        mag0[l] <= mag_in[l];
        neg0[l] <= neg_in[l];
        hh0[l]  <= mag_in[l][W-1:K] * mag_in[l][W-1:K];
        hl0[l]  <= mag_in[l][W-1:K] * mag_in[l][K-1:0];
        ll0[l]  <= mag_in[l][K-1:0] * mag_in[l][K-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: squares
  logic                     v1;
  logic [LANES-1:0][W-1:0]  mag1;
  logic [LANES-1:0]         neg1;
  logic [LANES-1:0][2*W-1:0] sq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag0;
      neg1 <= neg0;
      for (int l = 0; l < LANES; l++) begin
        sq1[l] <= ((2*W)'(hh0[l]) << (2*K)) + ((2*W)'(hl0[l]) << (K+1))
                  + (2*W)'(ll0[l]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: sum of squares
  logic                    v2;
  logic [SW-1:0]           sum2;
  logic [SIDE_W-1:0]       side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2  <= SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]);
      side2 <= {neg1, mag1};
    end
  end

  // --------------------------------------------------------------------------
  // square root cells, one root bit each
  logic [RW:0]               sv;
  logic [RW:0][SW-1:0]       srad;
  logic [RW:0][RW+1:0]       srem;
  logic [RW:0][RW-1:0]       sroot;
  logic [RW:0][SIDE_W-1:0]   sside;

  assign sv[0]    = v2;
  assign srad[0]  = sum2;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = side2;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    vnm_sqrt_cell #(.RW(RW), .SIDE_W(SIDE_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sv[i]),
      .in_rad    (srad[i]),
      .in_rem    (srem[i]),
      .in_root   (sroot[i]),
      .in_side   (sside[i]),
      .out_valid (sv[i+1]),
      .out_rad   (srad[i+1]),
      .out_rem   (srem[i+1]),
      .out_root  (sroot[i+1]),
      .out_side  (sside[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // divide cells, one quotient bit each
  logic [QW:0]                       dv;
  logic [QW:0][RW-1:0]               dd;
  logic [QW:0][LANES-1:0][RW:0]      dr;
  logic [QW:0][LANES-1:0][QW-1:0]    dq;
  logic [QW:0][LANES-1:0]            dneg;

  assign dv[0]   = sv[RW];
  assign dd[0]   = sroot[RW];
  assign dq[0]   = '0;
  assign dneg[0] = sside[RW][SIDE_W-1 -: LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_rinit
    assign dr[0][l] = (RW+1)'(sside[RW][l*W +: W]);
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    vnm_div_cell #(.RW(RW), .QW(QW), .FIRST(i == 0)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv[i]),
      .in_d      (dd[i]),
      .in_r      (dr[i]),
      .in_q      (dq[i]),
      .in_neg    (dneg[i]),
      .out_valid (dv[i+1]),
      .out_d     (dd[i+1]),
      .out_r     (dr[i+1]),
      .out_q     (dq[i+1]),
      .out_neg   (dneg[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // result formatting: zero vector, direction and speed saturation
  logic [LANES-1:0][DIR_W-1:0] dir_f;
  logic [SPEED_W-1:0]          speed_f;

  always_comb begin
    logic [QW+16:0] qx;
    logic [16:0]    clamp;
    logic [RW+SPEED_W-1:0] rootx;
    for (int l = 0; l < LANES; l++) begin
      qx = (QW+17)'(dq[QW][l]);
      if (dneg[QW][l]) begin
        clamp    = (qx > (QW+17)'(32768)) ? 17'd32768 : qx[16:0];
        dir_f[l] = DIR_W'(17'd0 - clamp);
      end else begin
        clamp    = (qx > (QW+17)'(32767)) ? 17'd32767 : qx[16:0];
        dir_f[l] = clamp[DIR_W-1:0];
      end
      if (dd[QW] == '0) begin
        dir_f[l] = '0;
      end
    end
    rootx   = (RW+SPEED_W)'(dd[QW]);
    speed_f = (|rootx[RW+SPEED_W-1:SPEED_W]) ? '1 : rootx[SPEED_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {speed_f, dir_f[2], dir_f[1], dir_f[0]};
    end
  end

  // --------------------------------------------------------------------------
  // checks
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not track the output register");

  a_zero_speed_zero_dir: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_TDATA_W-1 -: SPEED_W] == '0)
      |-> (m_tdata[LANES*DIR_W-1:0] == '0))
    else $error("zero length with nonzero direction");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present right after reset");

endmodule

`default_nettype wire

FILE: dv/tb_vector3_normalize_magnitude_unit.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalize_magnitude_unit
// Self-checking bench: directed and random vectors in, predicted length/direction checked
// against every result transfer, with bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_magnitude_unit
  import vnm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 32;
  localparam int DFRAC = 14;
  localparam int IN_TDATA_W = ((LANES * VW + 7) / 8) * 8;
  localparam int N_RANDOM = 1700;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   dz;
    logic [DIR_W-1:0]   dy;
    logic [DIR_W-1:0]   dx;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [IN_TDATA_W-1:0] vec_pending[$];
  norm_result_t          norm_expected[$];
  int  errors = 0;
  int  n_results = 0;
  bit  in_taken = 1'b0;

  vector3_normalize_magnitude_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // magnitude of a signed component, most negative value taken exactly
  function automatic logic [VW:0] comp_mag(input logic [VW-1:0] v);
    logic [VW:0] m;
    m = v[VW-1] ? ({1'b0, ~v} + 1) : {1'b0, v};
    return m;
  endfunction

  // truncated square root of the exact sum of squares
  function automatic logic [VW:0] isqrt_sum(input logic [2*VW+2:0] n);
    logic [VW:0] root;
    logic [VW:0] t;
    root = '0;
    for (int b = VW; b >= 0; b--) begin
      t = root | ((VW+1)'(1) << b);
      if ({(2*VW+3)'(t)} * (2*VW+3)'(t) <= n) root = t;
    end
    return root;
  endfunction

  function automatic logic [DIR_W-1:0] dir_comp(input logic [VW:0] m, input logic neg,
                                                input logic [VW:0] root);
    logic [VW+DFRAC+1:0] q;
    if (root == 0) return '0;
    q = ((VW+DFRAC+2)'(m) << DFRAC) / root;
    if (neg) begin
      if (q > 32768) q = 32768;
      return DIR_W'(17'h10000 - q[16:0]);
    end
    if (q > 32767) q = 32767;
    return q[DIR_W-1:0];
  endfunction

  function automatic norm_result_t predict_norm(input logic [IN_TDATA_W-1:0] d);
    logic [VW:0] m[3];
    logic neg[3];
    logic [2*VW+2:0] sum;
    logic [VW:0] root;
    norm_result_t r;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i*VW + VW-1];
      m[i] = comp_mag(d[i*VW +: VW]);
      sum += (2*VW+3)'(m[i]) * (2*VW+3)'(m[i]);
    end
    root = isqrt_sum(sum);
    r.dx = dir_comp(m[0], neg[0], root);
    r.dy = dir_comp(m[1], neg[1], root);
    r.dz = dir_comp(m[2], neg[2], root);
    r.speed = root[VW] ? '1 : root[SPEED_W-1:0];
    return r;
  endfunction

  function automatic logic [VW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(0, 8)) - 4;
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // input transfers seen at the rising edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      norm_expected.push_back(predict_norm(s_tdata));
      void'(vec_pending.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // driver: bursts of transfers with random gaps, changes on falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // hold the current item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (vec_pending.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= vec_pending[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: random-length windows, each ready or stalled at random
  int rdy_win = 0;
  always @(negedge clk) begin
    if (rdy_win == 0) begin
      rdy_win <= $urandom_range(1, 30);
      m_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      rdy_win <= rdy_win - 1;
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    norm_result_t got;
    norm_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      n_results++;
      if (norm_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
      end else begin
        want = norm_expected.pop_front();
        if (got.dx !== want.dx) begin
          errors++;
          $display("%0t: dir_x exp %h got %h", $realtime, want.dx, got.dx);
        end
        if (got.dy !== want.dy) begin
          errors++;
          $display("%0t: dir_y exp %h got %h", $realtime, want.dy, got.dy);
        end
        if (got.dz !== want.dz) begin
          errors++;
          $display("%0t: dir_z exp %h got %h", $realtime, want.dz, got.dz);
        end
        if (got.speed !== want.speed) begin
          errors++;
          $display("%0t: speed exp %h got %h", $realtime, want.speed, got.speed);
        end
      end
    end
  end

  initial begin
    logic [VW-1:0] ext[6];
    ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    // directed: zero vector, extremes, single-axis and mixed-sign vectors
    vec_pending.push_back('0);
    for (int i = 0; i < 6; i++) vec_pending.push_back({ext[i], ext[(i+2)%6], ext[(i+4)%6]});
    for (int i = 0; i < 6; i++) vec_pending.push_back({32'h0, 32'h0, ext[i]});
    for (int i = 0; i < 6; i++) vec_pending.push_back({32'h0, ext[i], 32'h0});
    vec_pending.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    vec_pending.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    vec_pending.push_back({32'hFFFF_0000, 32'h0001_0000, 32'h0});
    for (int i = 0; i < N_RANDOM; i++)
      vec_pending.push_back({rand_comp(), rand_comp(), rand_comp()});
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (vec_pending.size() == 0 && !s_tvalid);
    wait (norm_expected.size() == 0);
    repeat (60) @(posedge clk);
    $display("Checked %0d normalize results (directed extremes plus random vectors).",
             n_results);
    $display("Input bursts and output stalls were randomized throughout.");
    if (errors == 0 && norm_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/vnm_pkg.sv
rtl/vnm_sqrt_cell.sv
rtl/vnm_div_cell.sv
rtl/vector3_normalize_magnitude_unit.sv
dv/tb_vector3_normalize_magnitude_unit.sv
